[hdl/txcon_pkg.sv]
// Shared constants, payload types and controller/datapath interface types for the text console.
package txcon_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int POS_W = $clog2(CELLS);

	// Command codes
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Control characters
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0]  COLOR_RESET = 8'h07;
	localparam logic [15:0] CELL_RESET  = 16'h0720;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  char_code;
		logic [10:0] cell_addr;
	} in_item_t;

	typedef struct packed {
		logic [10:0] cursor_idx;
		logic [15:0] cell_data;
		logic        scrolled;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;     // capture the input item
		logic put;       // apply a put to the cursor and store
		logic ptr_zero;  // restart the sweep pointer
		logic copy;      // scroll copy step
		logic fill;      // blank fill step with current color
		logic init;      // reset fill step
		logic home;      // cursor to origin
		logic load_res;  // load the output register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic       scroll;
		logic       copy_end;
		logic       ptr_last;
		logic       res_free;
	} dp_stat_t;

endpackage

[hdl/txcon_ctrl.sv]
// Sequencing state machine for the text console.
module txcon_ctrl import txcon_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_COPY,
		S_FILL,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_INIT: begin
				cmd.init = 1'b1;
				if (stat.ptr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.ptr_zero = 1'b1;
				case (stat.cmd)
					CMD_PUT: begin
						cmd.put = 1'b1;
						state_d = stat.scroll ? S_COPY : S_DONE;
					end
					CMD_CLEAR: begin
						cmd.home = 1'b1;
						state_d  = S_FILL;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (stat.copy_end) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.ptr_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.res_free) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/txcon_dpath.sv]
// Cursor, cell store, sweep pointer and output register of the text console.
module txcon_dpath import txcon_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat
);

	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [POS_W-1:0] PTR_LAST  = POS_W'(CELLS - 1);
	localparam logic [POS_W-1:0] COPY_END  = POS_W'(CELLS - COLUMNS);
	localparam logic [POS_W-1:0] ROW_PITCH = POS_W'(COLUMNS);

	logic [15:0]      mem [CELLS];
	logic [15:0]      rdata_q;

	in_item_t         item_q;
	logic [7:0]       color_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             scr_q;
	logic [POS_W-1:0] ptr_q;
	logic             cp_v_s1;
	logic [POS_W-1:0] cp_addr_s1;
	logic             out_valid_q;
	out_item_t        out_item_q;

	logic [ROW_W-1:0] row_n;
	logic [COL_W-1:0] col_n;
	logic             wr_cell;
	logic             scroll;
	logic [POS_W-1:0] pos;
	logic             copy_issue;
	logic             mem_we;
	logic [POS_W-1:0] mem_waddr;
	logic [15:0]      mem_wdata;
	logic [POS_W-1:0] mem_raddr;
	logic             addr_ok;

	assign pos = POS_W'(POS_W'(row_q) * ROW_PITCH) + POS_W'(col_q);

	// Cursor move for a put
	always_comb begin
		row_n   = row_q;
		col_n   = col_q;
		wr_cell = 1'b0;
		scroll  = 1'b0;
		if (item_q.char_code == CH_CR) begin
			col_n = '0;
		end else if (item_q.char_code == CH_LF) begin
			col_n = '0;
			if (row_q == ROW_LAST) begin
				scroll = 1'b1;
			end else begin
				row_n = row_q + 1'b1;
			end
		end else if (item_q.char_code == CH_BS) begin
			if (col_q != '0) begin
				col_n = col_q - 1'b1;
			end else if (row_q != '0) begin
				row_n = row_q - 1'b1;
				col_n = COL_LAST;
			end
		end else begin
			wr_cell = 1'b1;
			if (col_q == COL_LAST) begin
				col_n = '0;
				if (row_q == ROW_LAST) begin
					scroll = 1'b1;
				end else begin
					row_n = row_q + 1'b1;
				end
			end else begin
				col_n = col_q + 1'b1;
			end
		end
		if (scroll) begin
			row_n = ROW_LAST;
			col_n = '0;
		end
	end

	assign copy_issue = cmd.copy && (ptr_q != COPY_END);
	assign mem_raddr  = copy_issue ? (ptr_q + ROW_PITCH) : POS_W'(item_q.cell_addr);
	assign addr_ok    = 32'(item_q.cell_addr) < CELLS;

	// One write port: copy drain, then fills, then the put write
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos;
		mem_wdata = {color_q, item_q.char_code};
		if (cp_v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = cp_addr_s1;
			mem_wdata = rdata_q;
		end else if (cmd.fill || cmd.init) begin
			mem_we    = 1'b1;
			mem_waddr = ptr_q;
			mem_wdata = cmd.init ? CELL_RESET : {color_q, CH_SPACE};
		end else if (cmd.put && wr_cell) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_item;
		end
		cp_addr_s1 <= ptr_q;
		if (cmd.load_res) begin
			out_item_q.cursor_idx <= 11'(pos);
			out_item_q.cell_data  <= (item_q.cmd == CMD_READ && addr_ok) ? rdata_q : 16'h0000;
			out_item_q.scrolled   <= scr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q     <= COLOR_RESET;
			row_q       <= '0;
			col_q       <= '0;
			scr_q       <= 1'b0;
			ptr_q       <= '0;
			cp_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				color_q <= cfg_wr_data;
			end
			if (cmd.latch) begin
				scr_q <= 1'b0;
			end else if (cmd.put) begin
				scr_q <= scroll;
			end
			if (cmd.home) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cmd.put) begin
				row_q <= row_n;
				col_q <= col_n;
			end
			if (cmd.ptr_zero) begin
				ptr_q <= '0;
			end else if (copy_issue || cmd.fill || cmd.init) begin
				ptr_q <= ptr_q + 1'b1;
			end
			cp_v_s1 <= copy_issue;
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cmd      = item_q.cmd;
	assign stat.scroll   = scroll;
	assign stat.copy_end = (ptr_q == COPY_END);
	assign stat.ptr_last = (ptr_q == PTR_LAST);
	assign stat.res_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[hdl/text_console_writer.sv]
// Top level of the text console: controller plus datapath.
// An item is taken in idle; a put without scroll, a read or an unused command passes through
// the execute and done states and presents its result once the output register is free, and
// the next item can be taken while that result is presented. A put that scrolls runs a copy
// sweep, then a bottom-row fill, and a clear fills every cell; both are bounded by the single
// write port of the cell store. After reset a clearing pass writes every cell once
// (ROWS*COLUMNS cells, 2000 as built) with input stalled; color writes are taken throughout.
module text_console_writer import txcon_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence each item: execute, sweep the store when needed, hand off the result
	txcon_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the cursor, color, cell store and the output register
	txcon_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule
